// ===== design/trilinear_vector_field_sampler_core_macros.svh =====
// Assertion macros for the trilinear vector field sampler core.
`ifndef TRILINEAR_VECTOR_FIELD_SAMPLER_CORE_MACROS_SVH
`define TRILINEAR_VECTOR_FIELD_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside of reset.
`define TVFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define TVFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TVFS_ASSERT(lbl, prop, msg)
`define TVFS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== design/tvfs_pkg.sv =====
// Package with field widths, codes and types of the trilinear vector field sampler.
`default_nettype none
package tvfs_pkg;

  localparam int VEL_W     = 16;
  localparam int POS_W     = 15;
  localparam int CELL_W    = 5;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CELL_BITS = 3 * VEL_W;

  localparam logic [CFG_W-1:0] GRID_SIZE_RST = 6'd32;

  typedef logic signed [VEL_W-1:0] vel_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE_X = 2'd0,
    CFG_GRID_SIZE_Y = 2'd1,
    CFG_GRID_SIZE_Z = 2'd2
  } cfg_idx_t;

endpackage
`default_nettype wire

// ===== design/trilinear_vector_field_sampler_core.sv =====
// Top level of the trilinear vector field sampler: banked cell store and lerp pipeline.
// Throughput: one beat per clock while out_stall is low, cell writes and samples alike,
// set by the six-stage pipeline and the eight parity-banked memories that return all
// corners in one read. A sample passes the split, bank read, x lerp, y lerp and z lerp
// stages to the output register; a cell write gives no result.
// Reset: synchronous, active low; clears the pipeline valids and sets the grid sizes
// to 32. The cell store is not cleared: a cell is undefined until written.
`default_nettype none
`include "trilinear_vector_field_sampler_core_macros.svh"
module trilinear_vector_field_sampler_core #(
  parameter int MAX_DIM   = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tvfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tvfs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [tvfs_pkg::CELL_W-1:0]         in_cell_x,
  input  logic [tvfs_pkg::CELL_W-1:0]         in_cell_y,
  input  logic [tvfs_pkg::CELL_W-1:0]         in_cell_z,
  input  logic signed [tvfs_pkg::VEL_W-1:0]   in_write_vel_x,
  input  logic signed [tvfs_pkg::VEL_W-1:0]   in_write_vel_y,
  input  logic signed [tvfs_pkg::VEL_W-1:0]   in_write_vel_z,
  input  logic signed [tvfs_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [tvfs_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [tvfs_pkg::POS_W-1:0]   in_pos_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tvfs_pkg::VEL_W-1:0]   out_sample_x,
  output logic signed [tvfs_pkg::VEL_W-1:0]   out_sample_y,
  output logic signed [tvfs_pkg::VEL_W-1:0]   out_sample_z
);

  localparam int DIM_W      = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int HW         = (DIM_W > 1) ? DIM_W - 1 : 1;
  localparam int BANK_AW    = 3 * HW;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int CW         = ((DIM_W > tvfs_pkg::CELL_W) ? DIM_W : tvfs_pkg::CELL_W) + 1;
  localparam int MD_W       = $clog2(MAX_DIM + 1);
  localparam int EW         = ((tvfs_pkg::CFG_W > MD_W) ? tvfs_pkg::CFG_W : MD_W) + 1;
  localparam int PCW        = ((tvfs_pkg::POS_W > EW + FRAC_BITS) ?
                               tvfs_pkg::POS_W : EW + FRAC_BITS) + 1;
  localparam int DIFF_W     = tvfs_pkg::VEL_W + 1;
  localparam int PROD_W     = DIFF_W + FRAC_BITS + 1;

  typedef struct packed {
    logic [DIM_W-1:0]     corner;
    logic [FRAC_BITS-1:0] frac;
  } split_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  // Clamp a position to 0..size-2 and split it into corner and fraction.
  function automatic split_t split_coord(input logic signed [tvfs_pkg::POS_W-1:0] pos,
                                         input logic [tvfs_pkg::CFG_W-1:0] size);
    logic [EW-1:0]         size_e;
    logic [EW-1:0]         eff;
    logic signed [PCW-1:0] p;
    logic signed [PCW-1:0] lim;
    split_t                s;
    size_e = EW'(size);
    if (size_e < EW'(2)) begin
      eff = EW'(2);
    end else if (size_e > EW'(MAX_DIM)) begin
      eff = EW'(MAX_DIM);
    end else begin
      eff = size_e;
    end
    p   = PCW'(pos);
    lim = $signed(PCW'(eff - EW'(2)) << FRAC_BITS);
    if (p < 0) begin
      p = '0;
    end else if (p > lim) begin
      p = lim;
    end
    s.corner = DIM_W'(p >>> FRAC_BITS);
    s.frac   = p[FRAC_BITS-1:0];
    return s;
  endfunction

  // Scaled difference of a lerp: (b - a) * f.
  function automatic prod_t lerp_mul(input tvfs_pkg::vel_t a, input tvfs_pkg::vel_t bv,
                                     input logic [FRAC_BITS-1:0] f);
    logic signed [DIFF_W-1:0]  d;
    logic signed [FRAC_BITS:0] fs;
    d  = DIFF_W'(bv) - DIFF_W'(a);
    fs = $signed({1'b0, f});
    return PROD_W'(d) * PROD_W'(fs);
  endfunction

  // Finish a lerp: a + (product >>> FRAC_BITS); the result stays between its ends.
  function automatic tvfs_pkg::vel_t lerp_add(input tvfs_pkg::vel_t a, input prod_t p);
    prod_t s;
    s = PROD_W'(a) + (p >>> FRAC_BITS);
    return tvfs_pkg::VEL_W'(s);
  endfunction

  // Grid size registers
  logic [tvfs_pkg::CFG_W-1:0] grid_size_x_r, grid_size_y_r, grid_size_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_x_r <= tvfs_pkg::GRID_SIZE_RST;
      grid_size_y_r <= tvfs_pkg::GRID_SIZE_RST;
      grid_size_z_r <= tvfs_pkg::GRID_SIZE_RST;
    end else if (cfg_we) begin
      case (tvfs_pkg::cfg_idx_t'(cfg_index))
        tvfs_pkg::CFG_GRID_SIZE_X: grid_size_x_r <= cfg_data;
        tvfs_pkg::CFG_GRID_SIZE_Y: grid_size_y_r <= cfg_data;
        tvfs_pkg::CFG_GRID_SIZE_Z: grid_size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the next stage loads
  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r, e_valid_r, out_valid_r;
  logic en_a, en_b, en_c, en_d, en_e, en_o;

  assign en_o     = !out_valid_r || !out_stall;
  assign en_e     = !e_valid_r || en_o;
  assign en_d     = !d_valid_r || en_e;
  assign en_c     = !c_valid_r || en_d;
  assign en_b     = !b_valid_r || en_c;
  assign en_a     = !a_valid_r || en_b;
  assign in_stall = !en_a;

  // Input split: corners and fractions for a sample, cell coordinates for a write
  split_t            sp_x, sp_y, sp_z;
  logic [CW-1:0]     cx_e, cy_e, cz_e;
  logic              wr_ok;
  tvfs_pkg::func_t   in_fn;
  logic [DIM_W-1:0]  a_x_nxt, a_y_nxt, a_z_nxt;

  assign in_fn = tvfs_pkg::func_t'(in_func);
  assign sp_x  = split_coord(in_pos_x, grid_size_x_r);
  assign sp_y  = split_coord(in_pos_y, grid_size_y_r);
  assign sp_z  = split_coord(in_pos_z, grid_size_z_r);
  assign cx_e  = CW'(in_cell_x);
  assign cy_e  = CW'(in_cell_y);
  assign cz_e  = CW'(in_cell_z);
  assign wr_ok = (cx_e < CW'(MAX_DIM)) && (cy_e < CW'(MAX_DIM)) && (cz_e < CW'(MAX_DIM));

  always_comb begin
    if (in_fn == tvfs_pkg::FUNC_SAMPLE) begin
      a_x_nxt = sp_x.corner;
      a_y_nxt = sp_y.corner;
      a_z_nxt = sp_z.corner;
    end else begin
      a_x_nxt = DIM_W'(in_cell_x);
      a_y_nxt = DIM_W'(in_cell_y);
      a_z_nxt = DIM_W'(in_cell_z);
    end
  end

  // Stage A: accepted beat
  tvfs_pkg::func_t                  a_func_r;
  logic                             a_wr_ok_r;
  logic [DIM_W-1:0]                 a_x_r, a_y_r, a_z_r;
  logic [FRAC_BITS-1:0]             a_fx_r, a_fy_r, a_fz_r;
  logic [tvfs_pkg::CELL_BITS-1:0]   a_vel_r;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_func_r  <= in_fn;
      a_wr_ok_r <= wr_ok;
      a_x_r     <= a_x_nxt;
      a_y_r     <= a_y_nxt;
      a_z_r     <= a_z_nxt;
      a_fx_r    <= sp_x.frac;
      a_fy_r    <= sp_y.frac;
      a_fz_r    <= sp_z.frac;
      a_vel_r   <= {in_write_vel_z, in_write_vel_y, in_write_vel_x};
    end
  end

  // Parity banks: bank {pz,py,px} holds the cells with those coordinate parities.
  // Beats pass the bank port in order, one per cycle while en_b is high, so no access overlaps.
  logic [7:0]                      bank_we;
  logic [tvfs_pkg::CELL_BITS-1:0]  bank_rd [8];

  for (genvar gb = 0; gb < 8; gb++) begin : g_bank
    localparam logic [2:0] PAR = 3'(gb);
    logic [DIM_W-1:0]               bx, by, bz;
    logic [BANK_AW-1:0]             addr;
    logic [tvfs_pkg::CELL_BITS-1:0] mem [BANK_DEPTH];
    logic [tvfs_pkg::CELL_BITS-1:0] rd_r;

    // Pick the corner of this parity: the base coordinate or the one after it
    assign bx   = (a_x_r[0] == PAR[0]) ? a_x_r : a_x_r + DIM_W'(1);
    assign by   = (a_y_r[0] == PAR[1]) ? a_y_r : a_y_r + DIM_W'(1);
    assign bz   = (a_z_r[0] == PAR[2]) ? a_z_r : a_z_r + DIM_W'(1);
    assign addr = {HW'(bz >> 1), HW'(by >> 1), HW'(bx >> 1)};

    assign bank_we[gb] = en_b && a_valid_r && (a_func_r == tvfs_pkg::FUNC_WRITE) &&
                         a_wr_ok_r && (a_x_r[0] == PAR[0]) && (a_y_r[0] == PAR[1]) &&
                         (a_z_r[0] == PAR[2]);

    always_ff @(posedge clk) begin
      if (bank_we[gb]) begin
        mem[addr] <= a_vel_r;
      end
      if (en_b) begin
        rd_r <= mem[addr];
      end
    end

    assign bank_rd[gb] = rd_r;
  end

  // Stage B: corner parities and fractions beside the bank read data
  logic [2:0]           b_par_r;
  logic [FRAC_BITS-1:0] b_fx_r, b_fy_r, b_fz_r;

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_par_r <= {a_z_r[0], a_y_r[0], a_x_r[0]};
      b_fx_r  <= a_fx_r;
      b_fy_r  <= a_fy_r;
      b_fz_r  <= a_fz_r;
    end
  end

  // Unscramble banks into corners: corner {dz,dy,dx} sits in bank {dz,dy,dx} ^ parity
  tvfs_pkg::vel_t corner_v [3][8];
  tvfs_pkg::vel_t c_a_nxt [3][4];
  prod_t          c_p_nxt [3][4];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 8; i++) begin
        corner_v[c][i] = bank_rd[3'(i) ^ b_par_r][c*tvfs_pkg::VEL_W +: tvfs_pkg::VEL_W];
      end
      for (int j = 0; j < 4; j++) begin
        c_a_nxt[c][j] = corner_v[c][2*j];
        c_p_nxt[c][j] = lerp_mul(corner_v[c][2*j], corner_v[c][2*j+1], b_fx_r);
      end
    end
  end

  // Stage C: x lerp products, lane j = {z,y}
  tvfs_pkg::vel_t       c_a_r [3][4];
  prod_t                c_p_r [3][4];
  logic [FRAC_BITS-1:0] c_fy_r, c_fz_r;

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_a_r  <= c_a_nxt;
      c_p_r  <= c_p_nxt;
      c_fy_r <= b_fy_r;
      c_fz_r <= b_fz_r;
    end
  end

  // Finish x lerps, start y lerps, lane k = z
  tvfs_pkg::vel_t d_e   [3][4];
  tvfs_pkg::vel_t d_a_nxt [3][2];
  prod_t          d_p_nxt [3][2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 4; j++) begin
        d_e[c][j] = lerp_add(c_a_r[c][j], c_p_r[c][j]);
      end
      for (int k = 0; k < 2; k++) begin
        d_a_nxt[c][k] = d_e[c][2*k];
        d_p_nxt[c][k] = lerp_mul(d_e[c][2*k], d_e[c][2*k+1], c_fy_r);
      end
    end
  end

  // Stage D: y lerp products
  tvfs_pkg::vel_t       d_a_r [3][2];
  prod_t                d_p_r [3][2];
  logic [FRAC_BITS-1:0] d_fz_r;

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_a_r  <= d_a_nxt;
      d_p_r  <= d_p_nxt;
      d_fz_r <= c_fz_r;
    end
  end

  // Finish y lerps, start the z lerp
  tvfs_pkg::vel_t e_f     [3][2];
  tvfs_pkg::vel_t e_a_nxt [3];
  prod_t          e_p_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 2; k++) begin
        e_f[c][k] = lerp_add(d_a_r[c][k], d_p_r[c][k]);
      end
      e_a_nxt[c] = e_f[c][0];
      e_p_nxt[c] = lerp_mul(e_f[c][0], e_f[c][1], d_fz_r);
    end
  end

  // Stage E: z lerp products
  tvfs_pkg::vel_t e_a_r [3];
  prod_t          e_p_r [3];

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_a_r <= e_a_nxt;
      e_p_r <= e_p_nxt;
    end
  end

  // Output register: finish the z lerp
  tvfs_pkg::vel_t sample_r [3];

  always_ff @(posedge clk) begin
    if (en_o) begin
      for (int c = 0; c < 3; c++) begin
        sample_r[c] <= lerp_add(e_a_r[c], e_p_r[c]);
      end
    end
  end

  // Valid chain; write beats drop out after the bank port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_r <= in_valid;
      end
      if (en_b) begin
        b_valid_r <= a_valid_r && (a_func_r == tvfs_pkg::FUNC_SAMPLE);
      end
      if (en_c) begin
        c_valid_r <= b_valid_r;
      end
      if (en_d) begin
        d_valid_r <= c_valid_r;
      end
      if (en_e) begin
        e_valid_r <= d_valid_r;
      end
      if (en_o) begin
        out_valid_r <= e_valid_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample_x = sample_r[0];
  assign out_sample_y = sample_r[1];
  assign out_sample_z = sample_r[2];

  // Assertions
  `TVFS_ASSERT(a_one_bank_wr, $onehot0(bank_we), "more than one bank written in a cycle")
  `TVFS_ASSERT_IMP(a_wr_drain, |bank_we, en_b && a_valid_r && (a_func_r == tvfs_pkg::FUNC_WRITE), "bank write without a draining write beat")
  `TVFS_ASSERT_IMP(a_stall_full, in_stall, a_valid_r && b_valid_r && c_valid_r && d_valid_r && e_valid_r && out_valid_r && out_stall, "input stalled with room in the pipeline")
  `TVFS_ASSERT_IMP(a_out_from_e, $rose(out_valid_r), $past(e_valid_r), "result appeared without a z lerp beat")
  `TVFS_ASSERT_IMP(a_corner_range, a_valid_r && (a_func_r == tvfs_pkg::FUNC_SAMPLE), (int'(a_x_r) <= MAX_DIM - 2) && (int'(a_y_r) <= MAX_DIM - 2) && (int'(a_z_r) <= MAX_DIM - 2), "sample corner beyond the store")

endmodule
`default_nettype wire

// ===== test/trilinear_vector_field_sampler_core_tb.sv =====
// Self-checking testbench for the trilinear vector field sampler core.
`default_nettype none
module trilinear_vector_field_sampler_core_tb;

  localparam int MAX_DIM     = 32;
  localparam int FRAC_BITS   = 8;
  localparam int CELLS       = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 212;

  typedef logic signed [tvfs_pkg::POS_W-1:0] pos_t;
  typedef logic [tvfs_pkg::CELL_W-1:0] cell_t;

  typedef struct {
    tvfs_pkg::func_t func;
    cell_t           cx, cy, cz;
    tvfs_pkg::vel_t  vx, vy, vz;
    pos_t            px, py, pz;
  } beat_t;

  typedef struct {
    tvfs_pkg::vel_t x, y, z;
  } sample_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tvfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tvfs_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  cell_t in_cell_x = '0, in_cell_y = '0, in_cell_z = '0;
  tvfs_pkg::vel_t in_write_vel_x = '0, in_write_vel_y = '0, in_write_vel_z = '0;
  pos_t in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tvfs_pkg::vel_t out_sample_x, out_sample_y, out_sample_z;

  trilinear_vector_field_sampler_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_cell_x(in_cell_x), .in_cell_y(in_cell_y), .in_cell_z(in_cell_z),
    .in_write_vel_x(in_write_vel_x), .in_write_vel_y(in_write_vel_y),
    .in_write_vel_z(in_write_vel_z),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_x(out_sample_x), .out_sample_y(out_sample_y),
    .out_sample_z(out_sample_z)
  );

  // Testbench state: predicted grid, sizes, planned writes, queues
  tvfs_pkg::vel_t cell_mem [0:2][0:CELLS-1];
  logic [tvfs_pkg::CFG_W-1:0] grid_cfg [0:2] = '{default: tvfs_pkg::GRID_SIZE_RST};
  bit planned [0:CELLS-1];
  beat_t pending_q [$];
  sample_t expected_samples [$];
  int error_cnt = 0;
  int accepted_cnt = 0;
  int phase_items = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int next_hold_at = 300;
  bit calm = 1'b0;
  logic in_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int eff_size(logic [tvfs_pkg::CFG_W-1:0] size);
    if (size < 2) return 2;
    if (size > MAX_DIM) return MAX_DIM;
    return int'(size);
  endfunction

  // Clamp one coordinate to the grid and split it into corner and fraction
  function automatic void split_axis(input pos_t pos, input logic [tvfs_pkg::CFG_W-1:0] size,
                                     output int corner, output int frac);
    int p, hi;
    hi = (eff_size(size) - 2) << FRAC_BITS;
    p = pos;
    if (p < 0) p = 0;
    if (p > hi) p = hi;
    corner = p >> FRAC_BITS;
    frac = p & ((1 << FRAC_BITS) - 1);
  endfunction

  function automatic int lerp(int a, int b, int f);
    return a + (((b - a) * f) >>> FRAC_BITS);
  endfunction

  // Blend the eight corners: four lerps along x, two along y, one along z
  function automatic sample_t interp_sample(pos_t px, pos_t py, pos_t pz);
    int x0, y0, z0, fx, fy, fz, c, i, e00, e10, e01, e11, e0, e1;
    int v [8];
    int r [3];
    sample_t s;
    split_axis(px, grid_cfg[0], x0, fx);
    split_axis(py, grid_cfg[1], y0, fy);
    split_axis(pz, grid_cfg[2], z0, fz);
    for (c = 0; c < 3; c++) begin
      for (i = 0; i < 8; i++)
        v[i] = cell_mem[c][((z0 + ((i >> 2) & 1)) * MAX_DIM + y0 + ((i >> 1) & 1)) * MAX_DIM
                           + x0 + (i & 1)];
      e00 = lerp(v[0], v[1], fx);
      e10 = lerp(v[2], v[3], fx);
      e01 = lerp(v[4], v[5], fx);
      e11 = lerp(v[6], v[7], fx);
      e0 = lerp(e00, e10, fy);
      e1 = lerp(e01, e11, fy);
      r[c] = lerp(e0, e1, fz);
    end
    s.x = tvfs_pkg::vel_t'(r[0]);
    s.y = tvfs_pkg::vel_t'(r[1]);
    s.z = tvfs_pkg::vel_t'(r[2]);
    return s;
  endfunction

  function automatic tvfs_pkg::vel_t rand_vel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return tvfs_pkg::vel_t'(-32768);
    if (r < 16) return tvfs_pkg::vel_t'(32767);
    if (r < 20) return tvfs_pkg::vel_t'(0);
    return tvfs_pkg::vel_t'($urandom);
  endfunction

  // Position along one axis: inside the grid, past either face, or anywhere
  function automatic pos_t rand_pos(int s);
    int r, p;
    r = $urandom_range(0, 99);
    if (r < 65) p = $urandom_range(0, (s - 1) << FRAC_BITS);
    else if (r < 75) p = -int'($urandom_range(1, 700));
    else if (r < 82) p = $urandom_range(0, 1) ? -16384 : 16383;
    else if (r < 88) p = ((s - 2) << FRAC_BITS) + int'($urandom_range(0, 2)) - 1;
    else p = $urandom;
    return pos_t'(p);
  endfunction

  function automatic beat_t rand_beat(tvfs_pkg::func_t f);
    beat_t b;
    b.func = f;
    b.cx = cell_t'($urandom);
    b.cy = cell_t'($urandom);
    b.cz = cell_t'($urandom);
    b.vx = tvfs_pkg::vel_t'($urandom);
    b.vy = tvfs_pkg::vel_t'($urandom);
    b.vz = tvfs_pkg::vel_t'($urandom);
    b.px = pos_t'($urandom);
    b.py = pos_t'($urandom);
    b.pz = pos_t'($urandom);
    return b;
  endfunction

  task automatic push_write(cell_t x, cell_t y, cell_t z, tvfs_pkg::vel_t vx,
                            tvfs_pkg::vel_t vy, tvfs_pkg::vel_t vz);
    beat_t b;
    b = rand_beat(tvfs_pkg::FUNC_WRITE);
    b.cx = x;
    b.cy = y;
    b.cz = z;
    b.vx = vx;
    b.vy = vy;
    b.vz = vz;
    pending_q.insert(pending_q.size(), b);
    planned[{z, y, x}] = 1'b1;
    phase_items++;
  endtask

  // Queue a sample, writing first any corner cell that has never been written
  task automatic push_sample(pos_t px, pos_t py, pos_t pz);
    beat_t b;
    int x0, y0, z0, f, i;
    cell_t cx, cy, cz;
    split_axis(px, grid_cfg[0], x0, f);
    split_axis(py, grid_cfg[1], y0, f);
    split_axis(pz, grid_cfg[2], z0, f);
    for (i = 0; i < 8; i++) begin
      cx = cell_t'(x0 + (i & 1));
      cy = cell_t'(y0 + ((i >> 1) & 1));
      cz = cell_t'(z0 + ((i >> 2) & 1));
      if (!planned[{cz, cy, cx}])
        push_write(cx, cy, cz, rand_vel(), rand_vel(), rand_vel());
    end
    b = rand_beat(tvfs_pkg::FUNC_SAMPLE);
    b.px = px;
    b.py = py;
    b.pz = pz;
    pending_q.insert(pending_q.size(), b);
    phase_items++;
  endtask

  task automatic run_random(int n);
    int s [3];
    int k, r;
    for (k = 0; k < 3; k++) s[k] = eff_size(grid_cfg[k]);
    phase_items = 0;
    while (phase_items < n) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        push_sample(rand_pos(s[0]), rand_pos(s[1]), rand_pos(s[2]));
      else if (r < 85)
        push_write(cell_t'($urandom_range(0, s[0] - 1)), cell_t'($urandom_range(0, s[1] - 1)),
                   cell_t'($urandom_range(0, s[2] - 1)), rand_vel(), rand_vel(), rand_vel());
      else
        push_write(cell_t'($urandom), cell_t'($urandom), cell_t'($urandom),
                   rand_vel(), rand_vel(), rand_vel());
    end
  endtask

  // Wait until every queued beat is in and every sample is out, then drain
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(tvfs_pkg::cfg_idx_t idx, logic [tvfs_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    grid_cfg[idx] = val;
  endtask

  task automatic set_sizes(logic [tvfs_pkg::CFG_W-1:0] sx, logic [tvfs_pkg::CFG_W-1:0] sy,
                           logic [tvfs_pkg::CFG_W-1:0] sz);
    cfg_write(tvfs_pkg::CFG_GRID_SIZE_X, sx);
    cfg_write(tvfs_pkg::CFG_GRID_SIZE_Y, sy);
    cfg_write(tvfs_pkg::CFG_GRID_SIZE_Z, sz);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Directed beats at the reset sizes: extreme corners, both clamps, max fraction
  task automatic run_directed();
    int i;
    phase_items = 0;
    for (i = 0; i < 8; i++)
      push_write(cell_t'(i & 1), cell_t'((i >> 1) & 1), cell_t'((i >> 2) & 1),
                 tvfs_pkg::vel_t'((i & 1) ? 32767 : -32768),
                 tvfs_pkg::vel_t'((i & 1) ? -32768 : 32767),
                 tvfs_pkg::vel_t'(i * 4096 - 16384));
    push_sample(pos_t'(0), pos_t'(0), pos_t'(0));
    push_sample(pos_t'(255), pos_t'(255), pos_t'(255));
    push_sample(pos_t'(-16384), pos_t'(-16384), pos_t'(-16384));
    push_sample(pos_t'(128), pos_t'(64), pos_t'(200));
    push_sample(pos_t'(16383), pos_t'(16383), pos_t'(16383));
  endtask

  // Driver: offer the next queued beat once the current one is taken
  always @(negedge clk) begin : drive_beats
    beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        in_func <= nxt.func;
        in_cell_x <= nxt.cx;
        in_cell_y <= nxt.cy;
        in_cell_z <= nxt.cz;
        in_write_vel_x <= nxt.vx;
        in_write_vel_y <= nxt.vy;
        in_write_vel_z <= nxt.vz;
        in_pos_x <= nxt.px;
        in_pos_y <= nxt.py;
        in_pos_z <= nxt.pz;
        in_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off now and then to back up the pipe
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (accepted_cnt >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left <= 250;
      next_hold_at <= next_hold_at + 900;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Predictor: apply each accepted input beat to the grid copy
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      accepted_cnt <= accepted_cnt + 1;
      if (in_func == tvfs_pkg::FUNC_WRITE) begin
        cell_mem[0][{in_cell_z, in_cell_y, in_cell_x}] = in_write_vel_x;
        cell_mem[1][{in_cell_z, in_cell_y, in_cell_x}] = in_write_vel_y;
        cell_mem[2][{in_cell_z, in_cell_y, in_cell_x}] = in_write_vel_z;
      end else begin
        expected_samples.insert(expected_samples.size(),
                                interp_sample(in_pos_x, in_pos_y, in_pos_z));
      end
    end
  end

  // Monitor: compare each output beat with the oldest predicted sample
  always @(posedge clk) begin : check_samples
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample beat: x %0d y %0d z %0d",
               out_sample_x, out_sample_y, out_sample_z);
        error_cnt++;
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_x !== want.x) begin
          $error("sample_x: expected %0d, actual %0d", want.x, out_sample_x);
          error_cnt++;
        end
        if (out_sample_y !== want.y) begin
          $error("sample_y: expected %0d, actual %0d", want.y, out_sample_y);
          error_cnt++;
        end
        if (out_sample_z !== want.z) begin
          $error("sample_z: expected %0d, actual %0d", want.z, out_sample_z);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus: directed beats, then random phases across grid sizes
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(PHASE_ITEMS - 21);
    wait_idle();
    set_sizes(6'd2, 6'd2, 6'd2);
    run_random(PHASE_ITEMS);
    wait_idle();
    // Out-of-range sizes act as the nearest legal size
    set_sizes(6'd0, 6'd1, 6'd63);
    run_random(PHASE_ITEMS);
    wait_idle();
    calm = 1'b1;
    set_sizes(6'd32, 6'd2, 6'd17);
    run_random(PHASE_ITEMS);
    wait_idle();
    calm = 1'b0;
    set_sizes(6'd3, 6'd32, 6'd2);
    run_random(PHASE_ITEMS);
    wait_idle();
    set_sizes(6'($urandom_range(2, 32)), 6'($urandom_range(2, 32)),
              6'($urandom_range(2, 32)));
    run_random(PHASE_ITEMS);
    wait_idle();
    calm = 1'b1;
    set_sizes(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)));
    run_random(PHASE_ITEMS);
    wait_idle();
    calm = 1'b0;
    set_sizes(6'd32, 6'd32, 6'd32);
    run_random(PHASE_ITEMS);
    wait_idle();
    if (error_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
